/* design/prq_pkg.sv */
package prq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  in_priority;
    logic [7:0]  in_proc_id;
    logic [31:0] in_stack_ptr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_priority;
    logic [7:0]  out_proc_id;
    logic [31:0] out_stack_ptr;
    logic [7:0]  occupancy;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  pid;
    logic [31:0] sp;
  } rec_t;

  typedef struct packed {
    logic    start;
    logic    shift;
    logic    place;
    logic    load;
    status_e res_st;
  } cmd_t;

  typedef struct packed {
    logic in_deq;
    logic full;
    logic empty;
    logic lower;
    logic pos_one;
    logic out_free;
  } sts_t;

endpackage

/* design/prq_ctrl.sv */
module prq_ctrl import prq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_PUT  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_comb begin
    state_d      = state_q;
    st_d         = st_q;
    cmd_o        = '0;
    cmd_o.res_st = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          st_d        = ST_OK;
          if (sts_i.in_deq) begin
            if (sts_i.empty) st_d = ST_EMPTY;
            state_d = S_FIN;
          end else if (sts_i.full) begin
            st_d    = ST_FULL;
            state_d = S_FIN;
          end else if (sts_i.empty) begin
            state_d = S_PUT;
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        // walk toward the head, moving lower priority entries up one slot
        if (sts_i.lower) begin
          cmd_o.shift = 1'b1;
          if (sts_i.pos_one) state_d = S_PUT;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_PUT: begin
        cmd_o.place = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* design/prq_datapath.sv */
module prq_datapath import prq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_word_t out_data_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  rec_t mem [QUEUE_DEPTH];
  rec_t rdata_q, rec_q, wr_data;

  logic [PW-1:0] head_q, wr_ptr_q, rd_ptr_q, tail, rd_addr;
  logic [PW:0]   tail_sum;
  logic [CW-1:0] count_q, pos_q;
  logic          deq_q, rd_en, wr_en, rec_ok, pop;
  out_word_t     out_q;
  logic          out_vld_q;

  // ring position one past the last stored entry
  assign tail_sum = {1'b0, head_q} + (PW + 1)'(count_q);
  assign tail     = (tail_sum >= DEPTH_W) ? PW'(tail_sum - DEPTH_W) : tail_sum[PW-1:0];

  assign rd_en   = cmd_i.start | cmd_i.shift;
  assign rd_addr = cmd_i.start ? ((in_data_i.func == FUNC_DEQ) ? head_q : ptr_dec(tail))
                               : ptr_dec(rd_ptr_q);
  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_data = cmd_i.shift ? rdata_q : rec_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
    if (wr_en) mem[wr_ptr_q] <= wr_data;
  end

  assign pop = cmd_i.start && (in_data_i.func == FUNC_DEQ) && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rec_q    <= '{prio: in_data_i.in_priority, pid: in_data_i.in_proc_id,
                    sp: in_data_i.in_stack_ptr};
      deq_q    <= in_data_i.func;
      pos_q    <= count_q;
      wr_ptr_q <= tail;
      rd_ptr_q <= ptr_dec(tail);
    end else if (cmd_i.shift) begin
      pos_q    <= pos_q - 1'b1;
      wr_ptr_q <= rd_ptr_q;
      rd_ptr_q <= ptr_dec(rd_ptr_q);
    end
  end

  assign rec_ok = (deq_q == FUNC_DEQ) && (cmd_i.res_st == ST_OK);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.status        <= cmd_i.res_st;
      out_q.out_valid     <= rec_ok;
      out_q.out_priority  <= rec_ok ? rdata_q.prio : '0;
      out_q.out_proc_id   <= rec_ok ? rdata_q.pid : '0;
      out_q.out_stack_ptr <= rec_ok ? rdata_q.sp : '0;
      out_q.occupancy     <= 8'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        head_q  <= ptr_inc(head_q);
        count_q <= count_q - 1'b1;
      end else if (cmd_i.place) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.load)        out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  assign sts_o.in_deq   = (in_data_i.func == FUNC_DEQ);
  assign sts_o.full     = (count_q == DEPTH_C);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.lower    = (rdata_q.prio < rec_q.prio);
  assign sts_o.pos_one  = (pos_q == CW'(1));
  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* design/priority_ready_queue.sv */
// Ready queue of process records (priority, process id, stack pointer), kept sorted with
// the highest priority at the head; equal priorities leave in arrival order. Every input
// word gives exactly one result word. An enqueue walks back from the tail one record
// per cycle through the read port and the write port of the record memory, moving each
// stored record of lower priority up one slot before it places the new record. A
// dequeue, a drop on a full queue and a dequeue on an empty one need no walk. The
// record memory needs no clearing after reset. A finished result waits in an output
// register while the next word is accepted.
module priority_ready_queue import prq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  prq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a second word while busy");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> sts.out_free)
    else $error("result overwrote a pending word");

  a_record_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_valid |-> out_data_o.status == ST_OK)
    else $error("record returned with error status");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |->
      out_data_o.out_priority == '0 && out_data_o.out_proc_id == '0 &&
      out_data_o.out_stack_ptr == '0)
    else $error("record fields not cleared");

endmodule

/* tb/priority_ready_queue_tb.sv */
`timescale 1ns / 1ps

module priority_ready_queue_tb;
  import prq_pkg::*;

  localparam int QDEPTH = 128;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT = 140;

  class queue_scoreboard;
    rec_t      ready_q[$];
    out_word_t expected_q[$];
    int        mismatches;

    // work out the result of one accepted word and update the sorted record list
    function void note_word(in_word_t w);
      out_word_t r;
      rec_t      rec;
      int        pos;
      bit        found;
      r = '0;
      if (w.func == FUNC_ENQ) begin
        if (ready_q.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          rec.prio = w.in_priority;
          rec.pid  = w.in_proc_id;
          rec.sp   = w.in_stack_ptr;
          // insert ahead of the first strictly lower priority
          pos = ready_q.size();
          found = 1'b0;
          for (int k = 0; k < ready_q.size() && !found; k++) begin
            if (ready_q[k].prio < rec.prio) begin
              pos = k;
              found = 1'b1;
            end
          end
          ready_q.insert(pos, rec);
          r.status = ST_OK;
        end
      end else begin
        if (ready_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          rec = ready_q.pop_front();
          r.status        = ST_OK;
          r.out_valid     = 1'b1;
          r.out_priority  = rec.prio;
          r.out_proc_id   = rec.pid;
          r.out_stack_ptr = rec.sp;
        end
      end
      r.occupancy = 8'(ready_q.size());
      expected_q.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      bit        bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with no expectation pending: %p", $realtime, got);
        return;
      end
      exp_w = expected_q.pop_front();
      bad = (got.status !== exp_w.status) || (got.out_valid !== exp_w.out_valid) ||
            (got.out_priority !== exp_w.out_priority) ||
            (got.out_proc_id !== exp_w.out_proc_id) ||
            (got.out_stack_ptr !== exp_w.out_stack_ptr) ||
            (got.occupancy !== exp_w.occupancy);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch st %0d/%0d vld %0d/%0d prio %0d/%0d pid %0d/%0d",
                   $realtime, exp_w.status, got.status, exp_w.out_valid, got.out_valid,
                   exp_w.out_priority, got.out_priority, exp_w.out_proc_id, got.out_proc_id);
          $display("    sp %h/%h occ %0d/%0d (expected/actual)", exp_w.out_stack_ptr,
                   got.out_stack_ptr, exp_w.occupancy, got.occupancy);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  queue_scoreboard sb = new();

  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int quiet_cycles;

  priority_ready_queue #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // both channels observed at the rising edge
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_word(in_data_i);
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic in_word_t make_word(logic f, int prio_hi);
    in_word_t w;
    w.func         = f;
    w.in_priority  = 8'($urandom_range(prio_hi, 0));
    w.in_proc_id   = 8'($urandom);
    w.in_stack_ptr = $urandom;
    return w;
  endfunction

  function automatic in_word_t enq_word(logic [7:0] prio, logic [7:0] pid, logic [31:0] sp);
    in_word_t w;
    w.func         = FUNC_ENQ;
    w.in_priority  = prio;
    w.in_proc_id   = pid;
    w.in_stack_ptr = sp;
    return w;
  endfunction

  task automatic run_mix(input int n, input int enq_pct, input int prio_hi);
    repeat (n) send_word(make_word(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                                   prio_hi));
  endtask

  task automatic set_traffic(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_cycles  = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty dequeue, extremes, ties, repeated process id
    send_word(make_word(FUNC_DEQ, 255));
    send_word(enq_word(8'd5, 8'd1, 32'h0000_0000));
    send_word(enq_word(8'd5, 8'd2, 32'hffff_ffff));
    send_word(enq_word(8'd255, 8'd255, 32'ha5a5_a5a5));
    send_word(enq_word(8'd0, 8'd0, 32'h5a5a_5a5a));
    send_word(enq_word(8'd5, 8'd1, 32'h1234_5678));
    send_word(enq_word(8'd100, 8'd128, 32'h8000_0001));
    send_word(enq_word(8'd255, 8'd7, 32'h7fff_fffe));
    send_word(enq_word(8'd0, 8'd200, 32'hdead_beef));
    repeat (9) send_word(make_word(FUNC_DEQ, 255));
    send_word(make_word(FUNC_DEQ, 0));

    // random phases: tie-heavy mix, then wide priorities
    set_traffic(0, 0);
    run_mix(100, 65, 7);
    run_mix(100, 40, 255);
    set_traffic(45, 0);
    run_mix(100, 65, 7);
    run_mix(100, 40, 255);
    set_traffic(0, 45);
    run_mix(100, 65, 7);
    run_mix(100, 40, 255);
    set_traffic(15, 15);
    run_mix(100, 65, 7);
    run_mix(100, 40, 255);

    // fill past full, then drain past empty
    run_mix(140, 100, 31);
    run_mix(145, 0, 0);

    // receiver holds off while words keep coming
    set_traffic(0, 0);
    hold_cycles = 400;
    run_mix(40, 70, 255);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("mismatches: %0d, results still expected: %0d", sb.mismatches, sb.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
